/* rtl/trimmed_mean_voltage_window_detector_assert.svh */
// assertion macros for the detector checker
`ifndef TRIMMED_MEAN_VOLTAGE_WINDOW_DETECTOR_ASSERT_SVH
`define TRIMMED_MEAN_VOLTAGE_WINDOW_DETECTOR_ASSERT_SVH

// same-cycle implication
`define TMVWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmvwd assertion failed");

// next-cycle implication
`define TMVWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmvwd assertion failed");

`endif

/* rtl/tmvwd_pkg.sv */
// types, constants and sizing for the trimmed mean voltage window detector
package tmvwd_pkg;

    localparam int WINDOW_LEN    = 10;
    localparam int TRIM_EACH_END = 2;
    localparam int SAMPLE_BITS   = 12;

    localparam int ADC_W       = 12;
    localparam int LEVEL_OUT_W = 12;
    localparam int THRESH_W    = 12;
    localparam int STATE_W     = 3;
    localparam int CFG_IDX_W   = 3;

    // trim shrinks so that at least one sample is averaged
    localparam int EFF_TRIM = (2 * TRIM_EACH_END < WINDOW_LEN) ?
                              TRIM_EACH_END : (WINDOW_LEN - 1) / 2;
    localparam int KEEP_N   = WINDOW_LEN - 2 * EFF_TRIM;
    localparam int RANK_LO  = EFF_TRIM;
    localparam int RANK_HI  = WINDOW_LEN - EFF_TRIM - 1;
    localparam int IDX_W    = $clog2(WINDOW_LEN);
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(KEEP_N);

    // floor(sum / KEEP_N) as (sum * DIV_MULT) >> DIV_SHIFT, exact for every sum
    localparam int     DIV_SHIFT = SUM_W + $clog2(KEEP_N);
    localparam longint DIV_MULT  = ((64'd1 << DIV_SHIFT) + KEEP_N - 1) / KEEP_N;
    localparam int     MULT_W    = $clog2(DIV_MULT + 1);
    localparam int     PROD_W    = SUM_W + MULT_W;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [THRESH_W-1:0]    t_thresh_val;

    typedef struct packed {
        t_thresh_val crit_low_enter;
        t_thresh_val crit_low_leave;
        t_thresh_val low_enter;
        t_thresh_val low_leave;
        t_thresh_val high_enter;
        t_thresh_val high_leave;
        t_thresh_val crit_high_enter;
        t_thresh_val crit_high_leave;
    } t_thresholds;

    localparam t_thresh_val RST_CRIT_LOW_ENTER  = 12'd860;
    localparam t_thresh_val RST_CRIT_LOW_LEAVE  = 12'd940;
    localparam t_thresh_val RST_LOW_ENTER       = 12'd1347;
    localparam t_thresh_val RST_LOW_LEAVE       = 12'd1399;
    localparam t_thresh_val RST_HIGH_ENTER      = 12'd2535;
    localparam t_thresh_val RST_HIGH_LEAVE      = 12'd2455;
    localparam t_thresh_val RST_CRIT_HIGH_ENTER = 12'd2856;
    localparam t_thresh_val RST_CRIT_HIGH_LEAVE = 12'd2777;

    typedef enum logic [STATE_W-1:0] {
        LVL_INIT  = 3'd0,
        LVL_CLOW  = 3'd1,
        LVL_LOW   = 3'd2,
        LVL_NORM  = 3'd3,
        LVL_HIGH  = 3'd4,
        LVL_CHIGH = 3'd5
    } t_level_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRIT_LOW_ENTER  = 3'd0,
        CFG_CRIT_LOW_LEAVE  = 3'd1,
        CFG_LOW_ENTER       = 3'd2,
        CFG_LOW_LEAVE       = 3'd3,
        CFG_HIGH_ENTER      = 3'd4,
        CFG_HIGH_LEAVE      = 3'd5,
        CFG_CRIT_HIGH_ENTER = 3'd6,
        CFG_CRIT_HIGH_LEAVE = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_RANK  = 3'd1,
        SEQ_MUL   = 3'd2,
        SEQ_DIV   = 3'd3,
        SEQ_CLASS = 3'd4
    } t_seq;

endpackage

/* rtl/tmvwd_classify.sv */
// hysteresis classifier: next level state from current state and filtered level
module tmvwd_classify (
    input  tmvwd_pkg::t_sample      i_level,
    input  tmvwd_pkg::t_thresholds  i_thr,
    input  tmvwd_pkg::t_level_state i_cur,
    output tmvwd_pkg::t_level_state o_next
);
    import tmvwd_pkg::*;

    logic [CMP_W-1:0] v;
    logic [CMP_W-1:0] cle, cll, le, ll, he, hl, che, chl;

    assign v   = CMP_W'(i_level);
    assign cle = CMP_W'(i_thr.crit_low_enter);
    assign cll = CMP_W'(i_thr.crit_low_leave);
    assign le  = CMP_W'(i_thr.low_enter);
    assign ll  = CMP_W'(i_thr.low_leave);
    assign he  = CMP_W'(i_thr.high_enter);
    assign hl  = CMP_W'(i_thr.high_leave);
    assign che = CMP_W'(i_thr.crit_high_enter);
    assign chl = CMP_W'(i_thr.crit_high_leave);

    // rules are checked in priority order, first hit wins
    always_comb begin
        o_next = i_cur;
        case (i_cur)
            LVL_INIT: begin
                if (v == '0)                   o_next = LVL_INIT;
                else if (v >= le && v < he)    o_next = LVL_NORM;
                else if (v < cle)              o_next = LVL_CLOW;
                else if (v < le && v >= cle)   o_next = LVL_LOW;
                else if (v >= che)             o_next = LVL_CHIGH;
                else if (v >= he && v < che)   o_next = LVL_HIGH;
                else                           o_next = LVL_INIT;
            end
            LVL_CLOW: begin
                if (v >= ll && v < he)         o_next = LVL_NORM;
                else if (v > cll && v < ll)    o_next = LVL_LOW;
                else if (v >= che)             o_next = LVL_CHIGH;
                else if (v >= he && v < che)   o_next = LVL_HIGH;
                else                           o_next = LVL_CLOW;
            end
            LVL_LOW: begin
                if (v < cle)                   o_next = LVL_CLOW;
                else if (v > ll && v < he)     o_next = LVL_NORM;
                else if (v >= che)             o_next = LVL_CHIGH;
                else if (v >= he && v < che)   o_next = LVL_HIGH;
                else                           o_next = LVL_LOW;
            end
            LVL_NORM: begin
                if (v < cle)                   o_next = LVL_CLOW;
                else if (v >= cle && v < le)   o_next = LVL_LOW;
                else if (v >= che)             o_next = LVL_CHIGH;
                else if (v > he && v < che)    o_next = LVL_HIGH;
                else                           o_next = LVL_NORM;
            end
            LVL_HIGH: begin
                if (v < cle)                   o_next = LVL_CLOW;
                else if (v >= cle && v < le)   o_next = LVL_LOW;
                else if (v >= le && v < hl)    o_next = LVL_NORM;
                else if (v > che)              o_next = LVL_CHIGH;
                else                           o_next = LVL_HIGH;
            end
            LVL_CHIGH: begin
                if (v < cle)                   o_next = LVL_CLOW;
                else if (v >= cle && v < le)   o_next = LVL_LOW;
                else if (v >= le && v < hl)    o_next = LVL_NORM;
                else if (v < chl)              o_next = LVL_HIGH;
                else                           o_next = LVL_CHIGH;
            end
            default: o_next = LVL_INIT;
        endcase
    end

endmodule

/* rtl/trimmed_mean_voltage_window_detector.sv */
// battery level monitor: trimmed mean over a sample window and hysteresis classifier
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  in       | sink      | i_in_valid / o_in_ready    | i_adc_sample
//  out      | source    | o_out_valid / i_out_ready  | o_filtered_level, o_level_state,
//           |           |                            | o_level_updated, o_state_report
//  cfg      | sink      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// a request that only fills the window goes straight from accept to the classify step
// a request that closes the window takes one rank step per window entry through the
// shared compare/rank unit, then multiply, shift and classify
// reset (synchronous, active low) restores thresholds, empties the window and shows init
// a stalled result holds in the output register; the next request is still taken and
// waits at the classify step until the output register frees up
module trimmed_mean_voltage_window_detector (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [tmvwd_pkg::ADC_W-1:0]            i_adc_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [tmvwd_pkg::LEVEL_OUT_W-1:0]      o_filtered_level,
    output logic [tmvwd_pkg::STATE_W-1:0]          o_level_state,
    output logic                                   o_level_updated,
    output logic                                   o_state_report,
    input  logic                                   i_cfg_we,
    input  logic [tmvwd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tmvwd_pkg::THRESH_W-1:0]         i_cfg_data
);
    import tmvwd_pkg::*;

    t_seq                   r_seq, n_seq;
    t_sample                r_window [WINDOW_LEN];
    logic [FILL_W-1:0]      r_fill;
    logic [IDX_W-1:0]       r_idx;
    logic [SUM_W-1:0]       r_sum;
    logic [PROD_W-1:0]      r_prod;
    t_sample                r_level;
    t_sample                r_sample;
    logic                   r_updated;
    t_level_state           r_pending;
    t_level_state           r_shown;
    t_thresholds            r_thr;

    logic                   r_out_valid;
    logic [LEVEL_OUT_W-1:0] r_out_level;
    t_level_state           r_out_state;
    logic                   r_out_updated;
    logic                   r_out_report;

    logic                   in_ready;
    logic                   in_acc;
    logic                   eval;
    logic                   out_free;
    logic                   rank_en;
    logic                   mul_en;
    logic                   div_en;
    logic                   class_en;
    t_sample                sample_in;
    t_sample                key;
    logic [WINDOW_LEN-1:0]  less;
    logic [IDX_W-1:0]       rank;
    logic                   keep;
    t_level_state           next_lvl;

    assign sample_in = t_sample'(i_adc_sample);
    assign eval      = (r_fill == FILL_W'(WINDOW_LEN));
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && in_ready;

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE:  if (i_in_valid) begin
                n_seq = eval ? SEQ_RANK : SEQ_CLASS;
            end
            SEQ_RANK:  if (r_idx == IDX_W'(WINDOW_LEN - 1)) begin
                n_seq = SEQ_MUL;
            end
            SEQ_MUL:   n_seq = SEQ_DIV;
            SEQ_DIV:   n_seq = SEQ_CLASS;
            SEQ_CLASS: if (out_free) begin
                n_seq = SEQ_IDLE;
            end
            default:   n_seq = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        rank_en  = 1'b0;
        mul_en   = 1'b0;
        div_en   = 1'b0;
        class_en = 1'b0;
        case (r_seq)
            SEQ_IDLE:  in_ready = 1'b1;
            SEQ_RANK:  rank_en  = 1'b1;
            SEQ_MUL:   mul_en   = 1'b1;
            SEQ_DIV:   div_en   = 1'b1;
            SEQ_CLASS: class_en = out_free;
            default:   in_ready = 1'b0;
        endcase
    end

    // shared rank unit: position of the selected entry in sorted order, ties by index
    assign key = r_window[r_idx];
    always_comb begin
        for (int j = 0; j < WINDOW_LEN; j++) begin
            less[j] = (r_window[j] < key) || ((r_window[j] == key) && (IDX_W'(j) < r_idx));
        end
    end
    assign rank = IDX_W'($countones(less));
    assign keep = (rank >= IDX_W'(RANK_LO)) && (rank <= IDX_W'(RANK_HI));

    tmvwd_classify u_classify (
        .i_level (r_level),
        .i_thr   (r_thr),
        .i_cur   (r_pending),
        .o_next  (next_lvl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_fill      <= '0;
            r_level     <= '0;
            r_pending   <= LVL_INIT;
            r_shown     <= LVL_INIT;
            r_out_valid <= 1'b0;
            r_thr       <= '{crit_low_enter:  RST_CRIT_LOW_ENTER,
                             crit_low_leave:  RST_CRIT_LOW_LEAVE,
                             low_enter:       RST_LOW_ENTER,
                             low_leave:       RST_LOW_LEAVE,
                             high_enter:      RST_HIGH_ENTER,
                             high_leave:      RST_HIGH_LEAVE,
                             crit_high_enter: RST_CRIT_HIGH_ENTER,
                             crit_high_leave: RST_CRIT_HIGH_LEAVE};
        end else begin
            r_seq <= n_seq;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CRIT_LOW_ENTER:  r_thr.crit_low_enter  <= i_cfg_data;
                    CFG_CRIT_LOW_LEAVE:  r_thr.crit_low_leave  <= i_cfg_data;
                    CFG_LOW_ENTER:       r_thr.low_enter       <= i_cfg_data;
                    CFG_LOW_LEAVE:       r_thr.low_leave       <= i_cfg_data;
                    CFG_HIGH_ENTER:      r_thr.high_enter      <= i_cfg_data;
                    CFG_HIGH_LEAVE:      r_thr.high_leave      <= i_cfg_data;
                    CFG_CRIT_HIGH_ENTER: r_thr.crit_high_enter <= i_cfg_data;
                    CFG_CRIT_HIGH_LEAVE: r_thr.crit_high_leave <= i_cfg_data;
                    default:             r_thr                 <= r_thr;
                endcase
            end
            if (in_acc && !eval) begin
                r_fill <= r_fill + 1'b1;
            end else if (div_en) begin
                r_fill <= FILL_W'(1);
            end
            if (div_en) begin
                r_level <= r_prod[DIV_SHIFT +: SAMPLE_BITS];
            end
            // the shown state takes the decision made on the previous request
            if (class_en) begin
                r_shown     <= r_pending;
                r_pending   <= next_lvl;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample  <= sample_in;
            r_idx     <= '0;
            r_sum     <= '0;
            r_updated <= eval;
            if (!eval) begin
                r_window[r_fill[IDX_W-1:0]] <= sample_in;
            end
        end
        if (rank_en) begin
            r_idx <= r_idx + 1'b1;
            if (keep) begin
                r_sum <= r_sum + SUM_W'(key);
            end
        end
        if (mul_en) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(DIV_MULT);
        end
        // window restarts with the sample that closed it
        if (div_en) begin
            r_window[0] <= r_sample;
        end
        if (class_en) begin
            r_out_level   <= LEVEL_OUT_W'(r_level);
            r_out_state   <= r_pending;
            r_out_updated <= r_updated;
            r_out_report  <= (r_pending != r_shown) && (r_pending != LVL_INIT);
        end
    end

    assign o_in_ready       = in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_filtered_level = r_out_level;
    assign o_level_state    = r_out_state;
    assign o_level_updated  = r_out_updated;
    assign o_state_report   = r_out_report;

endmodule

/* rtl/tmvwd_checker.sv */
// port-level checks for the detector, bound to the top level
`include "trimmed_mean_voltage_window_detector_assert.svh"

module tmvwd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [tmvwd_pkg::LEVEL_OUT_W-1:0]  o_filtered_level,
    input logic [tmvwd_pkg::STATE_W-1:0]      o_level_state,
    input logic                               o_level_updated,
    input logic                               o_state_report
);
    import tmvwd_pkg::*;

    // a stalled result keeps its payload
    `TMVWD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_filtered_level) && $stable(o_level_state) && $stable(o_level_updated) && $stable(o_state_report))

    // a report never announces the init state
    `TMVWD_ASSERT_NOW(a_report_not_init, i_clk, i_rst_n, o_out_valid && o_state_report, o_level_state != LVL_INIT)

    // one request at a time: busy right after an accept
    `TMVWD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind trimmed_mean_voltage_window_detector tmvwd_checker u_tmvwd_checker (.*);

/* tb/trimmed_mean_voltage_window_detector_tb.sv */
// self-checking testbench for the trimmed mean battery level window detector
module trimmed_mean_voltage_window_detector_tb;
    import tmvwd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 250;
    localparam int HOLD_EVERY     = 300;
    localparam logic [STATE_W-1:0] NO_STATE = 3'd7;
    localparam t_sample ADC_MAX = '1;

    localparam t_thresholds RESET_THRESHOLDS = {
        RST_CRIT_LOW_ENTER, RST_CRIT_LOW_LEAVE, RST_LOW_ENTER, RST_LOW_LEAVE,
        RST_HIGH_ENTER, RST_HIGH_LEAVE, RST_CRIT_HIGH_ENTER, RST_CRIT_HIGH_LEAVE
    };

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        logic [STATE_W-1:0]     state;
        logic                   updated;
        logic                   report;
    } t_level_report;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_BEAT} t_rx_mode;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic [ADC_W-1:0]       i_adc_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic [LEVEL_OUT_W-1:0] o_filtered_level;
    logic [STATE_W-1:0]     o_level_state;
    logic                   o_level_updated;
    logic                   o_state_report;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx    = '0;
    logic [THRESH_W-1:0]    i_cfg_data   = '0;

    trimmed_mean_voltage_window_detector DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // battery level model state
    t_sample            win_samples [WINDOW_LEN];
    int                 win_fill       = 0;
    t_sample            level_now      = '0;
    logic [STATE_W-1:0] state_active   = NO_STATE;
    t_level_state       state_next     = LVL_INIT;
    t_level_state       state_shown    = LVL_INIT;
    t_level_state       state_reported = LVL_INIT;
    t_thresholds        thr            = RESET_THRESHOLDS;

    t_sample        pending_samples [$];
    t_level_report  level_reports [$];
    logic           in_taken = 1'b0;
    int             fail_count = 0;
    int             samples_seen = 0;
    int             results_seen = 0;
    int             windows_seen = 0;
    int             reports_seen = 0;
    int             settings_used = 1;
    int             cycle_cnt = 0;

    function automatic t_level_state next_level(logic [STATE_W-1:0] cur, t_sample v);
        case (cur)
            LVL_INIT: begin
                if (v == 0) return LVL_INIT;
                if (v >= thr.low_enter && v < thr.high_enter) return LVL_NORM;
                if (v < thr.crit_low_enter) return LVL_CLOW;
                if (v < thr.low_enter && v >= thr.crit_low_enter) return LVL_LOW;
                if (v >= thr.crit_high_enter) return LVL_CHIGH;
                if (v >= thr.high_enter && v < thr.crit_high_enter) return LVL_HIGH;
                return LVL_INIT;
            end
            LVL_CLOW: begin
                if (v >= thr.low_leave && v < thr.high_enter) return LVL_NORM;
                if (v > thr.crit_low_leave && v < thr.low_leave) return LVL_LOW;
                if (v >= thr.crit_high_enter) return LVL_CHIGH;
                if (v >= thr.high_enter && v < thr.crit_high_enter) return LVL_HIGH;
                return LVL_CLOW;
            end
            LVL_LOW: begin
                if (v < thr.crit_low_enter) return LVL_CLOW;
                if (v > thr.low_leave && v < thr.high_enter) return LVL_NORM;
                if (v >= thr.crit_high_enter) return LVL_CHIGH;
                if (v >= thr.high_enter && v < thr.crit_high_enter) return LVL_HIGH;
                return LVL_LOW;
            end
            LVL_NORM: begin
                if (v < thr.crit_low_enter) return LVL_CLOW;
                if (v >= thr.crit_low_enter && v < thr.low_enter) return LVL_LOW;
                if (v >= thr.crit_high_enter) return LVL_CHIGH;
                if (v > thr.high_enter && v < thr.crit_high_enter) return LVL_HIGH;
                return LVL_NORM;
            end
            LVL_HIGH: begin
                if (v < thr.crit_low_enter) return LVL_CLOW;
                if (v >= thr.crit_low_enter && v < thr.low_enter) return LVL_LOW;
                if (v >= thr.low_enter && v < thr.high_leave) return LVL_NORM;
                if (v > thr.crit_high_enter) return LVL_CHIGH;
                return LVL_HIGH;
            end
            default: begin
                // crit high
                if (v < thr.crit_low_enter) return LVL_CLOW;
                if (v >= thr.crit_low_enter && v < thr.low_enter) return LVL_LOW;
                if (v >= thr.low_enter && v < thr.high_leave) return LVL_NORM;
                if (v < thr.crit_high_leave) return LVL_HIGH;
                return LVL_CHIGH;
            end
        endcase
    endfunction

    function automatic t_level_report step_level_model(t_sample sample);
        t_sample       sorted [WINDOW_LEN];
        t_sample       key;
        int            i;
        int            j;
        int            sum;
        t_level_report r;
        r.updated = 1'b0;
        r.report  = 1'b0;
        if (win_fill < WINDOW_LEN) begin
            win_samples[win_fill] = sample;
            win_fill++;
        end else begin
            sorted = win_samples;
            for (i = 1; i < WINDOW_LEN; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            sum = 0;
            for (i = RANK_LO; i <= RANK_HI; i++) sum += sorted[i];
            level_now = t_sample'(sum / KEEP_N);
            win_samples[0] = sample;
            win_fill = 1;
            r.updated = 1'b1;
        end
        // decision from the previous tick becomes visible now
        if (state_active != state_next) begin
            state_active = state_next;
            state_shown  = state_next;
        end
        state_next = next_level(state_active, level_now);
        if (state_shown != state_reported) begin
            r.report = (state_shown != LVL_INIT);
            state_reported = state_shown;
        end
        r.level = level_now;
        r.state = state_shown;
        return r;
    endfunction

    // results are checked before the new request is predicted in the same edge
    always @(posedge i_clk) begin : check_results
        t_level_report want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (level_reports.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = level_reports.pop_front();
                    results_seen++;
                    if (want.updated) windows_seen++;
                    if (want.report) reports_seen++;
                    if (o_filtered_level !== want.level) begin
                        $error("filtered_level: expected %0d, got %0d", want.level,
                               o_filtered_level);
                        fail_count++;
                    end
                    if (o_level_state !== want.state) begin
                        $error("level_state: expected %0d, got %0d", want.state,
                               o_level_state);
                        fail_count++;
                    end
                    if (o_level_updated !== want.updated) begin
                        $error("level_updated: expected %0d, got %0d", want.updated,
                               o_level_updated);
                        fail_count++;
                    end
                    if (o_state_report !== want.report) begin
                        $error("state_report: expected %0d, got %0d", want.report,
                               o_state_report);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                level_reports.push_back(step_level_model(i_adc_sample));
                samples_seen++;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CRIT_LOW_ENTER:  thr.crit_low_enter  = i_cfg_data;
                    CFG_CRIT_LOW_LEAVE:  thr.crit_low_leave  = i_cfg_data;
                    CFG_LOW_ENTER:       thr.low_enter       = i_cfg_data;
                    CFG_LOW_LEAVE:       thr.low_leave       = i_cfg_data;
                    CFG_HIGH_ENTER:      thr.high_enter      = i_cfg_data;
                    CFG_HIGH_LEAVE:      thr.high_leave      = i_cfg_data;
                    CFG_CRIT_HIGH_ENTER: thr.crit_high_enter = i_cfg_data;
                    CFG_CRIT_HIGH_LEAVE: thr.crit_high_leave = i_cfg_data;
                endcase
            end
        end
    end

    // sample sender: bursts and gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_in_valid   <= 1'b1;
                i_adc_sample <= pending_samples.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern plus a couple of long hold-offs
    int       hold_left  = 0;
    int       holds_done = 0;
    int       seg_left   = 0;
    int       rx_phase   = 0;
    t_rx_mode seg_mode   = RX_OPEN;

    always @(negedge i_clk) begin
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_done < 2 && results_seen >= (holds_done + 1) * HOLD_EVERY) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 80);
                seg_mode = t_rx_mode'($urandom_range(0, 3));
            end
            seg_left--;
            case (seg_mode)
                RX_OPEN:  i_out_ready <= 1'b1;
                RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                RX_CHOKE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:  i_out_ready <= (rx_phase % 5 != 0);
            endcase
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic wait_idle();
        while (pending_samples.size() != 0 || i_in_valid || level_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_thresh_val val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic write_thresholds(t_thresholds t);
        write_reg(CFG_CRIT_LOW_ENTER, t.crit_low_enter);
        write_reg(CFG_CRIT_LOW_LEAVE, t.crit_low_leave);
        write_reg(CFG_LOW_ENTER, t.low_enter);
        write_reg(CFG_LOW_LEAVE, t.low_leave);
        write_reg(CFG_HIGH_ENTER, t.high_enter);
        write_reg(CFG_HIGH_LEAVE, t.high_leave);
        write_reg(CFG_CRIT_HIGH_ENTER, t.crit_high_enter);
        write_reg(CFG_CRIT_HIGH_LEAVE, t.crit_high_leave);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // one window of samples, mostly aimed at a threshold edge
    task automatic queue_window();
        int      pick;
        int      target;
        int      s;
        int      k;
        pick = $urandom_range(0, 9);
        target = int'(t_sample'(thr >> (THRESH_W * $urandom_range(0, 7))))
                 + $urandom_range(0, 2) - 1;
        if (pick == 7) target = $urandom_range(0, 4095);
        if (pick == 9) target = ($urandom_range(0, 1) == 0) ? 0 : int'(ADC_MAX);
        for (k = 0; k < WINDOW_LEN; k++) begin
            if (pick < 4 || pick == 9) begin
                s = target;
            end else if (pick == 8) begin
                s = $urandom_range(0, 4095);
            end else begin
                s = target + $urandom_range(0, 80) - 40;
                if (pick != 7) s = target + $urandom_range(0, 6) - 3;
                // a few wild readings that the trim should mostly swallow
                if ($urandom_range(0, 9) < 2) s = $urandom_range(0, 4095);
            end
            if (s < 0) s = 0;
            if (s > int'(ADC_MAX)) s = int'(ADC_MAX);
            pending_samples.push_back(t_sample'(s));
        end
    endtask

    initial begin : stimulus
        t_thresholds t;
        int          shift;
        int          k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero window keeps init, then a full-scale window with low outliers trimmed
        repeat (WINDOW_LEN) pending_samples.push_back('0);
        pending_samples.push_back(ADC_MAX);
        pending_samples.push_back('0);
        pending_samples.push_back(ADC_MAX);
        pending_samples.push_back(ADC_MAX);
        pending_samples.push_back('0);
        repeat (5) pending_samples.push_back(ADC_MAX);
        repeat (20) queue_window();
        wait_idle();

        // ordered thresholds moved as a group
        shift = $urandom_range(0, 1600) - 800;
        for (k = 0; k < 8; k++)
            t[k*THRESH_W +: THRESH_W] =
                THRESH_W'(RESET_THRESHOLDS[k*THRESH_W +: THRESH_W] + shift);
        write_thresholds(t);
        repeat (20) queue_window();
        wait_idle();

        // arbitrary thresholds, usually inconsistent
        for (k = 0; k < 8; k++) t[k*THRESH_W +: THRESH_W] = THRESH_W'($urandom_range(0, 4095));
        write_thresholds(t);
        repeat (20) queue_window();
        wait_idle();

        write_thresholds('0);
        repeat (8) queue_window();
        wait_idle();

        write_thresholds('1);
        repeat (8) queue_window();
        wait_idle();

        for (k = 0; k < 8; k++)
            t[k*THRESH_W +: THRESH_W] = ($urandom_range(0, 1) == 0) ? '0 : ADC_MAX;
        write_thresholds(t);
        repeat (10) queue_window();
        wait_idle();

        write_thresholds(RESET_THRESHOLDS);
        repeat (7) queue_window();
        wait_idle();

        $display("run covered %0d samples and %0d trimmed-mean windows over %0d threshold sets",
                 samples_seen, windows_seen, settings_used);
        $display("%0d state reports seen, %0d long receiver hold-offs", reports_seen,
                 holds_done);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
